// File: rtl/core/bdhd_pkg.sv
package bdhd_pkg;

  localparam int TIME_W = 32;
  localparam int CFG_INDEX_W = 2;

  localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd20;
  localparam logic [TIME_W-1:0] HOLD_RESET = 32'd1000;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD = 2'd1;

endpackage

// File: rtl/core/button_debounce_hold_detector_unit.sv
// Channel  Direction  Handshake                      Payload
// sample   in         sample_valid / sample_stall    pin_level, tick, clear_press,
//                                                    clear_release, clear_hold
// result   out        result_valid / result_stall    press_flag, release_flag,
//                                                    hold_flag, is_pressed, press_duration
// config   in         cfg_write                      cfg_index, cfg_data
//
// A sample is captured in an input register and evaluated from there into the result
// register, which loads whenever it is not held by result_stall; one sample per cycle
// is sustained while result_stall is low. The path that sets the clock rate is the tick
// increment, the settle-time subtract and compare, and the hold compare.
// A synchronous reset clears valid and detector state and loads default settle/hold times.
// While the result register is held by result_stall, the input register stays
// occupied and sample_stall is raised only once it is full.
module button_debounce_hold_detector_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic                                 pin_level,
  input  logic                                 tick,
  input  logic                                 clear_press,
  input  logic                                 clear_release,
  input  logic                                 clear_hold,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic                                 press_flag,
  output logic                                 release_flag,
  output logic                                 hold_flag,
  output logic                                 is_pressed,
  output logic [bdhd_pkg::TIME_W-1:0]          press_duration,
  input  logic                                 cfg_write,
  input  logic [bdhd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bdhd_pkg::TIME_W-1:0]          cfg_data
);

  logic [bdhd_pkg::TIME_W-1:0] debounce_ms;
  logic [bdhd_pkg::TIME_W-1:0] hold_ms;

  logic s1_valid;
  logic s1_pin;
  logic s1_tick;
  logic s1_clr_press;
  logic s1_clr_release;
  logic s1_clr_hold;

  logic [bdhd_pkg::TIME_W-1:0] now_ms;
  logic                        last_raw;
  logic [bdhd_pkg::TIME_W-1:0] last_change_ms;
  logic                        pressed;
  logic [bdhd_pkg::TIME_W-1:0] press_stamp;
  logic                        waiting_hold;
  logic                        press_event;
  logic                        release_event;
  logic                        hold_event;

  logic [bdhd_pkg::TIME_W-1:0] now_ms_next;
  logic                        last_raw_next;
  logic [bdhd_pkg::TIME_W-1:0] last_change_ms_next;
  logic                        pressed_next;
  logic [bdhd_pkg::TIME_W-1:0] press_stamp_next;
  logic                        waiting_hold_next;
  logic                        press_event_next;
  logic                        release_event_next;
  logic                        hold_event_next;
  logic [bdhd_pkg::TIME_W-1:0] duration_next;

  logic                        out_advance;
  logic                        down_now;
  logic [bdhd_pkg::TIME_W-1:0] settle_time;
  logic [bdhd_pkg::TIME_W-1:0] held_time;
  logic [bdhd_pkg::TIME_W-1:0] cur_duration;

  assign out_advance  = !result_valid || !result_stall;
  assign sample_stall = s1_valid && !out_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= bdhd_pkg::DEBOUNCE_RESET;
      hold_ms     <= bdhd_pkg::HOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bdhd_pkg::REG_DEBOUNCE: debounce_ms <= cfg_data;
        bdhd_pkg::REG_HOLD:     hold_ms     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!sample_stall) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s1_pin         <= pin_level;
      s1_tick        <= tick;
      s1_clr_press   <= clear_press;
      s1_clr_release <= clear_release;
      s1_clr_hold    <= clear_hold;
    end
  end

  always_comb begin
    down_now     = !s1_pin;
    now_ms_next  = s1_tick ? now_ms + 1'b1 : now_ms;
    settle_time  = now_ms_next - last_change_ms;
    held_time    = now_ms_next - press_stamp;
    cur_duration = pressed ? held_time : press_stamp;

    last_raw_next       = last_raw;
    last_change_ms_next = last_change_ms;
    pressed_next        = pressed;
    press_stamp_next    = press_stamp;
    waiting_hold_next   = waiting_hold;
    press_event_next    = press_event;
    release_event_next  = release_event;
    hold_event_next     = hold_event;
    duration_next       = cur_duration;

    if (down_now != last_raw) begin
      last_change_ms_next = now_ms_next;
      last_raw_next       = down_now;
    end else if (settle_time >= debounce_ms) begin
      if (down_now && !pressed) begin
        pressed_next      = 1'b1;
        press_stamp_next  = last_change_ms;
        press_event_next  = 1'b1;
        waiting_hold_next = 1'b1;
        duration_next     = settle_time;
      end else if (!down_now && pressed) begin
        pressed_next       = 1'b0;
        waiting_hold_next  = 1'b0;
        press_stamp_next   = last_change_ms - press_stamp;
        release_event_next = 1'b1;
        duration_next      = last_change_ms - press_stamp;
      end else if (waiting_hold && cur_duration >= hold_ms) begin
        waiting_hold_next = 1'b0;
        hold_event_next   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms         <= '0;
      last_raw       <= 1'b0;
      last_change_ms <= '0;
      pressed        <= 1'b0;
      press_stamp    <= '0;
      waiting_hold   <= 1'b0;
      press_event    <= 1'b0;
      release_event  <= 1'b0;
      hold_event     <= 1'b0;
    end else if (s1_valid && out_advance) begin
      now_ms         <= now_ms_next;
      last_raw       <= last_raw_next;
      last_change_ms <= last_change_ms_next;
      pressed        <= pressed_next;
      press_stamp    <= press_stamp_next;
      waiting_hold   <= waiting_hold_next;
      press_event    <= press_event_next && !s1_clr_press;
      release_event  <= release_event_next && !s1_clr_release;
      hold_event     <= hold_event_next && !s1_clr_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_advance) begin
      press_flag     <= press_event_next;
      release_flag   <= release_event_next;
      hold_flag      <= hold_event_next;
      is_pressed     <= pressed_next;
      press_duration <= duration_next;
    end
  end

  // A pending hold check only exists during a debounced press.
  assert property (@(posedge clk) disable iff (rst) waiting_hold |-> pressed)
    else $error("hold check pending while released");

  // The debounced state only follows a raw level that has already been recorded.
  assert property (@(posedge clk) disable iff (rst) $rose(pressed) |-> last_raw)
    else $error("press accepted against the recorded raw level");

  assert property (@(posedge clk) disable iff (rst) $fell(pressed) |-> !last_raw)
    else $error("release accepted against the recorded raw level");

  // The millisecond clock moves only when a sample is evaluated.
  assert property (@(posedge clk) disable iff (rst)
      !(s1_valid && out_advance) |=> $stable(now_ms))
    else $error("time advanced without a sample");

endmodule
